// ===== src/tqe_pkg.sv =====
`default_nettype none
package tqe_pkg;
  localparam int NUM_TIMERS = 16;
  localparam int MAX_FIRE = 15;
  localparam int TIME_BITS = 48;
  localparam int SLOT_W = $clog2(NUM_TIMERS);
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RK_ADD = 2'd0,
    RK_CANCEL = 2'd1,
    RK_FIRED = 2'd2,
    RK_DONE = 2'd3
  } rkind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic act;
    logic emit;
  } tqe_cmd_t;

  typedef struct packed {
    logic scan_last;
    rkind_t kind;
    logic idle_op;
  } tqe_stat_t;
endpackage
`default_nettype wire

// ===== src/tqe_ctrl.sv =====
`default_nettype none
module tqe_ctrl import tqe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire logic      out_stall,
  output logic           out_valid,
  input  wire tqe_stat_t st,
  output tqe_cmd_t       cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.idle_op) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
          if (st.scan_last) state_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        cmd.act = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.emit = 1'b1;
          if (st.kind == RK_FIRED) begin
            cmd.scan_clr = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/tqe_dp.sv =====
`default_nettype none
module tqe_dp import tqe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire tqe_cmd_t    cmd,
  output tqe_stat_t        st,
  input  wire logic [1:0]  in_op,
  input  wire logic [47:0] in_expire_at,
  input  wire logic [31:0] in_period,
  input  wire logic [31:0] in_cancel_id,
  input  wire logic [47:0] in_now_time,
  output logic [1:0]       out_result_kind,
  output logic [31:0]      out_timer_id,
  output logic             out_success,
  output logic [6:0]       out_fire_count,
  output logic             out_more_pending,
  output logic             out_last
);
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [NUM_TIMERS-1:0] valid_r;
  logic [31:0]           id_mem   [NUM_TIMERS];
  logic [TIME_BITS-1:0]  exp_mem  [NUM_TIMERS];
  logic [31:0]           per_mem  [NUM_TIMERS];

  logic [1:0]           op_r;
  logic [TIME_BITS-1:0] tval_r;
  logic [31:0]          per_r, key_r, ctr_r, newid;
  logic [SLOT_W-1:0]    idx_r;
  logic                 hit_r, free_r;
  logic [SLOT_W-1:0]    hit_slot_r, free_slot_r;
  logic                 best_r;
  logic [SLOT_W-1:0]    best_slot_r;
  logic [TIME_BITS-1:0] best_exp_r;
  logic [31:0]          best_id_r, best_per_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [1:0]           okind_r;
  logic [31:0]          oid_r;
  logic                 ook_r, omore_r;

  // Registered read port: the slot addressed in one scan cycle is compared
  // in the next one.
  logic                 rd_ok_r, rd_v_r;
  logic [SLOT_W-1:0]    rd_slot_r;
  logic [31:0]          rd_id_r, rd_per_r;
  logic [TIME_BITS-1:0] rd_exp_r;

  function automatic logic [31:0] inc_nz(input logic [31:0] v);
    logic [31:0] t;
    t = v + 32'd1;
    if (t == '0) t = 32'd1;
    return t;
  endfunction

  assign newid = inc_nz(inc_nz(ctr_r));

  logic due, better;
  assign due = rd_v_r && (rd_exp_r <= tval_r);
  assign better = !best_r || (rd_exp_r < best_exp_r) ||
                  ((rd_exp_r == best_exp_r) && (rd_id_r < best_id_r));

  logic [TIME_BITS:0] sum;
  assign sum = {1'b0, best_exp_r} + {{(TIME_BITS-31){1'b0}}, best_per_r};

  assign st.scan_last = rd_ok_r && (rd_slot_r == SLOT_W'(NUM_TIMERS-1));
  assign st.kind = rkind_t'(okind_r);
  assign st.idle_op = (op_r == OP_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ctr_r <= '0;
      op_r <= OP_NONE;
    end else begin
      if (cmd.load) begin
        op_r <= in_op;
        if (in_op == OP_ADD) ctr_r <= newid;
      end
      if (cmd.act) begin
        case (op_r)
          OP_ADD: if (free_r && !hit_r) valid_r[free_slot_r] <= 1'b1;
          OP_CANCEL: if (hit_r) valid_r[hit_slot_r] <= 1'b0;
          OP_TICK: if (best_r && cnt_r != CNT_W'(MAX_FIRE) && best_per_r == '0)
            valid_r[best_slot_r] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.emit) op_r <= (okind_r == RK_FIRED) ? OP_TICK : OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tval_r <= (in_op == OP_ADD) ? in_expire_at[TIME_BITS-1:0]
                                  : in_now_time[TIME_BITS-1:0];
      per_r <= in_period;
      key_r <= (in_op == OP_ADD) ? newid : in_cancel_id;
      cnt_r <= '0;
    end
    if (cmd.scan_clr) begin
      idx_r <= '0;
      rd_ok_r <= 1'b0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
      best_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      idx_r <= idx_r + SLOT_W'(1);
      rd_ok_r <= 1'b1;
      rd_slot_r <= idx_r;
      rd_v_r <= valid_r[idx_r];
      rd_id_r <= id_mem[idx_r];
      rd_exp_r <= exp_mem[idx_r];
      rd_per_r <= per_mem[idx_r];
      if (rd_ok_r) begin
        if (rd_v_r && rd_id_r == key_r && !hit_r) begin
          hit_r <= 1'b1;
          hit_slot_r <= rd_slot_r;
        end
        if (!rd_v_r && !free_r) begin
          free_r <= 1'b1;
          free_slot_r <= rd_slot_r;
        end
        if (due && better) begin
          best_r <= 1'b1;
          best_slot_r <= rd_slot_r;
          best_exp_r <= rd_exp_r;
          best_id_r <= rd_id_r;
          best_per_r <= rd_per_r;
        end
      end
    end
    if (cmd.act) begin
      ook_r <= 1'b0;
      oid_r <= '0;
      omore_r <= 1'b0;
      case (op_r)
        OP_ADD: begin
          okind_r <= RK_ADD;
          if (free_r && !hit_r) begin
            id_mem[free_slot_r] <= key_r;
            exp_mem[free_slot_r] <= tval_r;
            per_mem[free_slot_r] <= per_r;
            oid_r <= key_r;
            ook_r <= 1'b1;
          end
        end
        OP_CANCEL: begin
          okind_r <= RK_CANCEL;
          ook_r <= hit_r;
        end
        default: begin
          if (best_r && cnt_r != CNT_W'(MAX_FIRE)) begin
            okind_r <= RK_FIRED;
            oid_r <= best_id_r;
            cnt_r <= cnt_r + CNT_W'(1);
            if (best_per_r != '0)
              exp_mem[best_slot_r] <= sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
          end else begin
            okind_r <= RK_DONE;
            omore_r <= best_r;
          end
        end
      endcase
    end
    if (!rst_n) cnt_r <= '0;
  end

  assign out_result_kind = okind_r;
  assign out_timer_id = oid_r;
  assign out_success = ook_r;
  assign out_fire_count = (okind_r == RK_DONE) ? cnt_r : '0;
  assign out_more_pending = omore_r;
  assign out_last = (okind_r != RK_FIRED);

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_FIRE)) else $error("fire count over limit");
  a_ctr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && in_op == OP_ADD |=> ctr_r != '0) else $error("zero id");
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.act) && ook_r && okind_r == RK_ADD |-> oid_r != '0)
    else $error("add ok with zero id");
`endif
endmodule
`default_nettype wire

// ===== src/timer_queue_engine.sv =====
`default_nettype none
// Timer queue engine: a table of NUM_TIMERS one-shot or periodic timers.
// Input channel (in_valid/in_stall) carries one item: op add, cancel or tick
// with its expiry, period, id and current time. Result channel
// (out_valid/out_stall) returns one item per add or cancel, and for a tick
// one item per fired timer followed by a tick-done item with the count.
// out_last marks the final result of each input item; op 3 gives none.
// Every add, cancel or tick walks the table one slot per cycle through a
// single registered read port on the slot store, and a tick walks it again
// for each fired timer and once more for the tick-done item.
// One item is processed at a time; in_stall is high until its last result
// has been taken. A stalled result is held in the output register, and the
// engine waits. Synchronous active-low reset empties the table and clears
// the id counter; no clearing pass is needed.
module timer_queue_engine import tqe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [47:0] in_expire_at,
  input  wire logic [31:0] in_period,
  input  wire logic [31:0] in_cancel_id,
  input  wire logic [47:0] in_now_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [31:0]      out_timer_id,
  output logic             out_success,
  output logic [6:0]       out_fire_count,
  output logic             out_more_pending,
  output logic             out_last
);
  tqe_cmd_t  cmd;
  tqe_stat_t st;

  tqe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .st(st), .cmd(cmd)
  );

  tqe_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_op(in_op), .in_expire_at(in_expire_at), .in_period(in_period),
    .in_cancel_id(in_cancel_id), .in_now_time(in_now_time),
    .out_result_kind(out_result_kind), .out_timer_id(out_timer_id),
    .out_success(out_success), .out_fire_count(out_fire_count),
    .out_more_pending(out_more_pending), .out_last(out_last)
  );
endmodule
`default_nettype wire
